// File: rtl/mlt_pkg.sv
// Shared types and defaults for the MAC learning table.
package mlt_pkg;

    localparam int MLT_TABLE_ENTRIES = 64;
    localparam int MLT_DOMAIN_BITS   = 12;
    localparam int MLT_PORT_BITS     = 8;

    typedef enum logic [1:0] {
        CMD_LEARN  = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd        cmd;
        logic [47:0] mac;
        logic [11:0] domain_id;
        logic [7:0]  port_id;
    } t_in_item;

    typedef struct packed {
        logic       found;
        logic [7:0] result_port;
        logic       moved;
        logic       inserted;
        logic       table_full;
    } t_out_item;

endpackage

// File: rtl/mac_learning_table.sv
// Top level of the layer-2 MAC learning table with its output register.
//
//   channel  dir  handshake                 payload
//   in       in   i_in_valid / o_in_stall   i_in_data   (t_in_item)
//   out      out  o_out_valid / i_out_stall o_out_data  (t_out_item)
//
// After reset the table runs a clearing pass over all TABLE_ENTRIES entries with
// o_in_stall high. A request then scans the table: the table read walks one
// entry per cycle and stops at a key match.
// A finished result sits in the output register while the next request is
// taken; the engine holds its next result until that register is free.
module mac_learning_table
    import mlt_pkg::*;
#(
    parameter int TABLE_ENTRIES = MLT_TABLE_ENTRIES,
    parameter int DOMAIN_BITS   = MLT_DOMAIN_BITS,
    parameter int PORT_BITS     = MLT_PORT_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    logic      eng_idle;
    logic      eng_done;
    t_out_item eng_res;
    logic      res_take;

    logic      r_out_vld, n_out_vld;
    t_out_item r_out, n_out;

    mlt_engine #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .DOMAIN_BITS  (DOMAIN_BITS),
        .PORT_BITS    (PORT_BITS)
    ) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_in_valid && eng_idle),
        .i_req     (i_in_data),
        .o_idle    (eng_idle),
        .o_done    (eng_done),
        .o_res     (eng_res),
        .i_res_take(res_take)
    );

    assign res_take = !r_out_vld || !i_out_stall;

    always_comb begin
        n_out_vld = r_out_vld;
        n_out     = r_out;
        if (eng_done && res_take) begin
            n_out_vld = 1'b1;
            n_out     = eng_res;
        end else if (!i_out_stall) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
        r_out <= n_out;
    end

    assign o_in_stall  = !eng_idle;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// File: rtl/mlt_engine.sv
// Address table storage with a sequencer that scans one entry per cycle.
module mlt_engine
    import mlt_pkg::*;
#(
    parameter int TABLE_ENTRIES = MLT_TABLE_ENTRIES,
    parameter int DOMAIN_BITS   = MLT_DOMAIN_BITS,
    parameter int PORT_BITS     = MLT_PORT_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_in_item  i_req,
    output logic      o_idle,
    output logic      o_done,
    output t_out_item o_res,
    input  logic      i_res_take
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int KW = 48 + DOMAIN_BITS;

    typedef struct packed {
        logic                 vld;
        logic [KW-1:0]        key;
        logic [PORT_BITS-1:0] port;
    } t_entry;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_WRITE = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_entry r_mem [TABLE_ENTRIES];

    t_state               r_state, n_state;
    logic [IW:0]          r_idx, n_idx;
    logic                 r_rd_ok, n_rd_ok;
    logic [IW-1:0]        r_rd_idx, n_rd_idx;
    t_entry               r_rd_data;
    t_cmd                 r_cmd, n_cmd;
    logic [KW-1:0]        r_key, n_key;
    logic [PORT_BITS-1:0] r_port, n_port;
    logic                 r_hit, n_hit;
    logic [IW-1:0]        r_hit_idx, n_hit_idx;
    logic [PORT_BITS-1:0] r_hit_port, n_hit_port;
    logic                 r_free_ok, n_free_ok;
    logic [IW-1:0]        r_free_idx, n_free_idx;
    t_out_item            r_res, n_res;

    logic                 w_en;
    logic [IW-1:0]        w_addr;
    t_entry               w_data;
    logic                 match;
    logic                 last;

    assign match = r_rd_ok && r_rd_data.vld && (r_rd_data.key == r_key);
    assign last  = (r_rd_idx == IW'(TABLE_ENTRIES - 1));

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_rd_ok    = 1'b0;
        n_rd_idx   = r_idx[IW-1:0];
        n_cmd      = r_cmd;
        n_key      = r_key;
        n_port     = r_port;
        n_hit      = r_hit;
        n_hit_idx  = r_hit_idx;
        n_hit_port = r_hit_port;
        n_free_ok  = r_free_ok;
        n_free_idx = r_free_idx;
        n_res      = r_res;
        w_en       = 1'b0;
        w_addr     = r_idx[IW-1:0];
        w_data     = '0;
        case (r_state)
            S_CLEAR: begin
                w_en  = 1'b1;
                n_idx = r_idx + 1'b1;
                if (r_idx[IW-1:0] == IW'(TABLE_ENTRIES - 1)) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_cmd     = i_req.cmd;
                    n_key     = {DOMAIN_BITS'(i_req.domain_id), i_req.mac};
                    n_port    = PORT_BITS'(i_req.port_id);
                    n_hit     = 1'b0;
                    n_free_ok = 1'b0;
                    n_idx     = '0;
                    n_state   = (i_req.cmd == CMD_NONE) ? S_WRITE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_idx != (IW + 1)'(TABLE_ENTRIES)) begin
                    n_rd_ok = 1'b1;
                    n_idx   = r_idx + 1'b1;
                end
                if (r_rd_ok) begin
                    if (match) begin
                        n_hit      = 1'b1;
                        n_hit_idx  = r_rd_idx;
                        n_hit_port = r_rd_data.port;
                        n_state    = S_WRITE;
                    end else begin
                        if (!r_rd_data.vld && !r_free_ok) begin
                            n_free_ok  = 1'b1;
                            n_free_idx = r_rd_idx;
                        end
                        if (last) begin
                            n_state = S_WRITE;
                        end
                    end
                end
            end
            S_WRITE: begin
                n_res = '0;
                if (r_cmd != CMD_NONE && r_hit) begin
                    n_res.found       = 1'b1;
                    n_res.result_port = 8'(r_hit_port);
                end
                case (r_cmd)
                    CMD_LEARN: begin
                        if (r_hit) begin
                            if (r_hit_port != r_port) begin
                                w_en        = 1'b1;
                                w_addr      = r_hit_idx;
                                w_data      = '{vld: 1'b1, key: r_key, port: r_port};
                                n_res.moved = 1'b1;
                            end
                        end else if (r_free_ok) begin
                            w_en           = 1'b1;
                            w_addr         = r_free_idx;
                            w_data         = '{vld: 1'b1, key: r_key, port: r_port};
                            n_res.inserted = 1'b1;
                        end else begin
                            n_res.table_full = 1'b1;
                        end
                    end
                    CMD_DELETE: begin
                        if (r_hit) begin
                            w_en   = 1'b1;
                            w_addr = r_hit_idx;
                            w_data = '{vld: 1'b0, key: r_key, port: r_hit_port};
                        end
                    end
                    default: begin
                    end
                endcase
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
        r_rd_data <= r_mem[r_idx[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_idx   <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_rd_ok <= n_rd_ok;
        end
        r_rd_idx   <= n_rd_idx;
        r_cmd      <= n_cmd;
        r_key      <= n_key;
        r_port     <= n_port;
        r_hit      <= n_hit;
        r_hit_idx  <= n_hit_idx;
        r_hit_port <= n_hit_port;
        r_free_ok  <= n_free_ok;
        r_free_idx <= n_free_idx;
        r_res      <= n_res;
    end

    assign o_idle = (r_state == S_IDLE);
    assign o_done = (r_state == S_DONE);
    assign o_res  = r_res;

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for mac_learning_table: directed and random learn, lookup, delete and no-op traffic.
module tb_top;
    import mlt_pkg::*;

    localparam int STN_COUNT   = 96;
    localparam int PHASES      = 8;
    localparam int PHASE_REQS  = 205;
    localparam int HOLD_AFTER  = 500;
    localparam int HOLD_CYCLES = 600;
    localparam logic [47:0] MAC_ONES = 48'hFFFF_FFFF_FFFF;
    localparam logic [11:0] DOM_ONES = 12'hFFF;

    typedef struct {
        t_in_item req;
        bit       drain;
    } t_pending;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    // table image kept by the predictor
    bit          tbl_valid [MLT_TABLE_ENTRIES];
    logic [59:0] tbl_key   [MLT_TABLE_ENTRIES];
    logic [7:0]  tbl_port  [MLT_TABLE_ENTRIES];

    t_pending  req_queue [$];
    t_out_item expected_q [$];

    int total_reqs = 0;
    int acc_cnt = 0;
    int rsp_cnt = 0;
    int err_cnt = 0;
    int n_learn = 0, n_lookup = 0, n_delete = 0, n_noop = 0;
    int n_insert = 0, n_move = 0, n_full = 0, n_hit = 0;

    bit        req_taken = 1'b0;
    bit        offering = 1'b0;
    int        gap_left = 0;
    t_pending  nxt;
    t_in_item  cur_req = '0;
    t_out_item fresh;
    t_out_item want;
    t_out_item got;
    bit        hold_done = 1'b0;
    int        hold_left = 0;
    int        stall_left = 0;

    mac_learning_table dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #30000000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic t_out_item table_apply(t_in_item req);
        t_out_item   res;
        logic [59:0] k;
        int          hit;
        int          slot;
        int          i;
        res  = '0;
        hit  = -1;
        slot = -1;
        k    = {req.domain_id, req.mac};
        if (req.cmd != CMD_NONE) begin
            for (i = 0; i < MLT_TABLE_ENTRIES; i++)
                if (hit < 0 && tbl_valid[i] && tbl_key[i] == k) hit = i;
            if (hit >= 0) begin
                res.found       = 1'b1;
                res.result_port = tbl_port[hit];
            end
        end
        case (req.cmd)
            CMD_LEARN: begin
                if (hit >= 0) begin
                    if (tbl_port[hit] != req.port_id) begin
                        tbl_port[hit] = req.port_id;
                        res.moved     = 1'b1;
                    end
                end else begin
                    for (i = 0; i < MLT_TABLE_ENTRIES; i++)
                        if (slot < 0 && !tbl_valid[i]) slot = i;
                    if (slot >= 0) begin
                        tbl_valid[slot] = 1'b1;
                        tbl_key[slot]   = k;
                        tbl_port[slot]  = req.port_id;
                        res.inserted    = 1'b1;
                    end else begin
                        res.table_full = 1'b1;
                    end
                end
            end
            CMD_DELETE: begin
                if (hit >= 0) tbl_valid[hit] = 1'b0;
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic bit quiet_phase();
        return ((acc_cnt / 120) % 4) == 2;
    endfunction

    task automatic add_req(t_cmd c, logic [47:0] mac, logic [11:0] dom, logic [7:0] port);
        t_pending p;
        p.req.cmd       = c;
        p.req.mac       = mac;
        p.req.domain_id = dom;
        p.req.port_id   = port;
        p.drain         = 1'b0;
        req_queue.push_back(p);
        total_reqs++;
    endtask

    task automatic add_drain();
        t_pending p;
        p.req   = '0;
        p.drain = 1'b1;
        req_queue.push_back(p);
    endtask

    task automatic check_field(string fname, int exp_val, int act_val);
        if (exp_val != act_val) begin
            err_cnt++;
            if (err_cnt <= 40)
                $display("%0t: %s mismatch, expected %0d, got %0d",
                         $time, fname, exp_val, act_val);
        end
    endtask

    // sender: offer requests from the queue, hold each until taken
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (req_taken) begin
                offering = 1'b0;
                gap_left = quiet_phase() ? 0 : idle_len();
            end
            if (!offering) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (req_queue.size() > 0) begin
                    if (req_queue[0].drain) begin
                        if (expected_q.size() == 0) req_queue.delete(0);
                    end else begin
                        nxt      = req_queue.pop_front();
                        cur_req  = nxt.req;
                        offering = 1'b1;
                    end
                end
            end
            i_in_valid <= offering;
            i_in_data  <= cur_req;
        end
    end

    // receiver: random stalls plus one long hold-off
    always @(negedge i_clk) begin
        if (!hold_done && rsp_cnt >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            if (!quiet_phase() && $urandom_range(0, 3) == 0) stall_left = idle_len();
        end
    end

    // predict on each accepted request, check each accepted result
    always @(posedge i_clk) begin
        req_taken <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            fresh = table_apply(i_in_data);
            expected_q.push_back(fresh);
            acc_cnt++;
            case (i_in_data.cmd)
                CMD_LEARN:  n_learn++;
                CMD_LOOKUP: n_lookup++;
                CMD_DELETE: n_delete++;
                default:    n_noop++;
            endcase
            n_insert += int'(fresh.inserted);
            n_move   += int'(fresh.moved);
            n_full   += int'(fresh.table_full);
            n_hit    += int'(fresh.found);
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            rsp_cnt++;
            got = o_out_data;
            if (expected_q.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected result, expected none, got %h", $time, got);
            end else begin
                want = expected_q.pop_front();
                check_field("found", int'(want.found), int'(got.found));
                check_field("result_port", int'(want.result_port), int'(got.result_port));
                check_field("moved", int'(want.moved), int'(got.moved));
                check_field("inserted", int'(want.inserted), int'(got.inserted));
                check_field("table_full", int'(want.table_full), int'(got.table_full));
            end
        end
    end

    initial begin : run_ctl
        logic [47:0] stn_mac  [STN_COUNT];
        logic [11:0] stn_dom  [STN_COUNT];
        logic [7:0]  stn_port [STN_COUNT];
        logic [63:0] r64;
        logic [47:0] mac;
        logic [11:0] dom;
        logic [7:0]  port;
        t_cmd        c;
        int          k;
        int          r;
        int          ph;
        int          n;
        bit          filling;

        for (k = 0; k < MLT_TABLE_ENTRIES; k++) tbl_valid[k] = 1'b0;

        for (k = 0; k < STN_COUNT; k++) begin
            r64          = {$urandom(), $urandom()};
            stn_mac[k]   = r64[47:0];
            stn_dom[k]   = 12'($urandom_range(0, 4095));
            stn_port[k]  = 8'($urandom_range(0, 255));
            if (k % 8 == 1) stn_mac[k] = stn_mac[k-1];
            if (k % 8 == 2) begin
                stn_dom[k] = stn_dom[k-1];
                stn_mac[k] = stn_mac[k-1] ^ (48'd1 << $urandom_range(0, 47));
            end
        end

        add_req(CMD_LOOKUP, MAC_ONES, DOM_ONES, 8'hFF);
        add_req(CMD_LEARN,  MAC_ONES, DOM_ONES, 8'hFF);
        add_req(CMD_LEARN,  48'd0,    12'd0,    8'h00);
        add_req(CMD_LOOKUP, MAC_ONES, DOM_ONES, 8'h00);
        add_req(CMD_LEARN,  MAC_ONES, DOM_ONES, 8'hFF);
        add_req(CMD_LEARN,  MAC_ONES, DOM_ONES, 8'h00);
        add_req(CMD_LOOKUP, 48'd0,    12'd0,    8'hFF);
        add_req(CMD_DELETE, 48'd0,    12'd0,    8'h00);
        add_req(CMD_DELETE, 48'd0,    12'd0,    8'h00);
        add_req(CMD_LOOKUP, 48'd0,    12'd0,    8'h00);
        add_req(CMD_NONE,   MAC_ONES, DOM_ONES, 8'hFF);
        add_req(CMD_LEARN,  MAC_ONES, 12'd0,    8'h3C);
        add_req(CMD_LEARN,  48'd0,    DOM_ONES, 8'hA5);
        add_req(CMD_LOOKUP, MAC_ONES, 12'd0,    8'h00);
        add_req(CMD_DELETE, MAC_ONES, DOM_ONES, 8'h00);
        add_req(CMD_LEARN,  48'd0,    12'd0,    8'h5A);
        add_req(CMD_LEARN,  MAC_ONES, DOM_ONES, 8'hC3);
        add_req(CMD_DELETE, MAC_ONES, 12'd0,    8'hFF);
        add_req(CMD_LOOKUP, MAC_ONES, DOM_ONES, 8'h00);
        add_drain();

        // alternate fill-heavy and churn-heavy phases over a key pool larger than the table
        for (ph = 0; ph < PHASES; ph++) begin
            filling = (ph % 2 == 0);
            for (n = 0; n < PHASE_REQS; n++) begin
                k = $urandom_range(0, STN_COUNT - 1);
                r = $urandom_range(0, 99);
                if (r < 5)                        c = CMD_NONE;
                else if (r < (filling ? 70 : 45)) c = CMD_LEARN;
                else if (r < (filling ? 88 : 70)) c = CMD_LOOKUP;
                else                              c = CMD_DELETE;
                if ($urandom_range(0, 99) < 8) begin
                    r64 = {$urandom(), $urandom()};
                    mac = r64[47:0];
                    dom = 12'($urandom_range(0, 4095));
                end else begin
                    mac = stn_mac[k];
                    dom = stn_dom[k];
                end
                if ($urandom_range(0, 3) == 0) stn_port[k] = 8'($urandom_range(0, 255));
                port = (c == CMD_LEARN) ? stn_port[k] : 8'($urandom_range(0, 255));
                add_req(c, mac, dom, port);
            end
            add_drain();
        end

        do @(negedge i_clk); while (!(acc_cnt == total_reqs && expected_q.size() == 0));
        repeat (MLT_TABLE_ENTRIES + 8) @(negedge i_clk);

        $display("Covered %0d requests: %0d learn (%0d new, %0d moved, %0d refused as full),",
                 acc_cnt, n_learn, n_insert, n_move, n_full);
        $display("  %0d lookup, %0d delete, %0d no-op; %0d key hits; %0d mismatches",
                 n_lookup, n_delete, n_noop, n_hit, err_cnt);
        if (err_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/mlt_pkg.sv
rtl/mlt_engine.sv
rtl/mac_learning_table.sv
verif/tb_top.sv
